### rtl/vtm_pkg.sv
// ----------------------------------------------------------------------------
// Variometer tone mapper package
// Shared widths, breakpoint tables, segment tables and codes.
// ----------------------------------------------------------------------------
package vtm_pkg;

   // Field widths
   localparam int X_W     = 12;  // climb rate, signed cm/s
   localparam int HZ_W    = 11;  // tone frequency
   localparam int MS_W    = 10;  // millisecond fields
   localparam int MODE_W  = 2;
   localparam int CSR_W   = 12;  // widest register
   localparam int CSR_IDX_W = 3;

   // Breakpoint table geometry
   localparam int ROM_LEN          = 20;
   localparam int DEF_NUM_POINTS   = 20;
   localparam int IDX_W            = $clog2(ROM_LEN);

   // Interpolation datapath widths
   localparam int DXX_W       = 7;   // offset into a segment, at most 100
   localparam int DY_W        = 9;   // signed step between two table entries
   localparam int NUM_W       = 18;  // interpolation numerator, below 2**18
   localparam int RECIP_W     = 21;  // reciprocal of a segment length
   localparam int RECIP_SHIFT = 25;  // NUM_W plus the bits of the longest segment
   localparam int Q_W         = 11;  // interpolated value

   localparam logic signed [X_W-1:0] CLIMB_CLAMP = 12'sd1000;

   typedef int int_rom_type [ROM_LEN];

   localparam int_rom_type BP_X = '{
      0, 20, 40, 60, 80, 100, 125, 150, 175, 200,
      225, 250, 350, 424, 500, 600, 700, 800, 900, 1000
   };
   localparam int_rom_type BP_HZ = '{
      300, 350, 400, 450, 500, 550, 600, 650, 700, 750,
      800, 850, 950, 1050, 1150, 1300, 1450, 1600, 1700, 1800
   };
   localparam int_rom_type BP_MS = '{
      200, 190, 180, 170, 160, 150, 140, 130, 120, 110,
      100, 90, 80, 70, 60, 50, 45, 40, 35, 30
   };

   // ceil(2**RECIP_SHIFT / segment length); entry i covers BP_X[i-1]..BP_X[i]
   localparam int_rom_type SEG_RECIP = '{
      0,
      1677722, 1677722, 1677722, 1677722, 1677722,
      1342178, 1342178, 1342178, 1342178, 1342178, 1342178,
      335545, 453439, 441506,
      335545, 335545, 335545, 335545, 335545
   };

   // Segment length per segment
   function automatic int_rom_type dx_table();
      int_rom_type r;
      r[0] = 0;
      for (int i = 1; i < ROM_LEN; i++) begin
         r[i] = BP_X[i] - BP_X[i-1];
      end
      return r;
   endfunction

   // Left value times segment length per segment
   function automatic int_rom_type base_table(int_rom_type ys);
      int_rom_type r;
      r[0] = 0;
      for (int i = 1; i < ROM_LEN; i++) begin
         r[i] = ys[i-1] * (BP_X[i] - BP_X[i-1]);
      end
      return r;
   endfunction

   // Rise of the value across each segment
   function automatic int_rom_type slope_table(int_rom_type ys);
      int_rom_type r;
      r[0] = 0;
      for (int i = 1; i < ROM_LEN; i++) begin
         r[i] = ys[i] - ys[i-1];
      end
      return r;
   endfunction

   localparam int_rom_type SEG_DX = dx_table();

   typedef enum logic [MODE_W-1:0] {
      MODE_SILENT = 2'd0,
      MODE_CLIMB  = 2'd1,
      MODE_SINK   = 2'd2
   } tone_mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CLIMB_THR   = 3'd0,
      CSR_SINK_THR    = 3'd1,
      CSR_SINK_HZ     = 3'd2,
      CSR_SINK_PERIOD = 3'd3,
      CSR_IDLE_PERIOD = 3'd4
   } csr_index_type;

   // Stage load strobes handed to the interpolation lanes
   typedef struct packed {
      logic load2;
      logic load3;
   } vtm_ctl_type;

endpackage

### rtl/vtm_interp.sv
// ----------------------------------------------------------------------------
// Variometer tone mapper interpolation lane
// Two pipeline stages: numerator build, then reciprocal multiply and floor.
// ----------------------------------------------------------------------------
module vtm_interp import vtm_pkg::*; #(
   parameter int_rom_type Y_TABLE = BP_HZ
) (
   input  logic              clock,
   input  vtm_ctl_type       ctl,
   input  logic [IDX_W-1:0]  seg,
   input  logic [DXX_W-1:0]  dxx,
   output logic [Q_W-1:0]    q
);

   localparam int_rom_type BASE = base_table(Y_TABLE);
   localparam int_rom_type DY   = slope_table(Y_TABLE);
   localparam int PROD_W = DXX_W + 1 + DY_W;
   localparam int SUM_W  = NUM_W + 2;
   localparam int MUL_W  = NUM_W + RECIP_W;

   logic signed [DY_W-1:0]    dy;
   logic signed [DXX_W:0]     dxx_s;
   logic signed [PROD_W-1:0]  prod;
   logic signed [SUM_W-1:0]   sum;
   logic [NUM_W-1:0]          num_in, num_ff;
   logic [IDX_W-1:0]          seg_in, seg_ff;
   logic [MUL_W-1:0]          mul;
   logic [Q_W-1:0]            q_in, q_ff;

   // Stage 2: numerator = left value * length + offset * rise (never negative)
   always_comb begin
      dy     = DY_W'(DY[seg]);
      dxx_s  = {1'b0, dxx};
      prod   = dxx_s * dy;
      sum    = $signed({2'b00, NUM_W'(BASE[seg])})
             + {{(SUM_W-PROD_W){prod[PROD_W-1]}}, prod};
      num_in = sum[NUM_W-1:0];
      seg_in = seg;
   end

   // Stage 3: floor divide by segment length via exact reciprocal
   always_comb begin
      mul  = num_ff * RECIP_W'(SEG_RECIP[seg_ff]);
      q_in = mul[RECIP_SHIFT +: Q_W];
   end

   always_ff @(posedge clock) begin
      if (ctl.load2) begin
         num_ff <= num_in;
         seg_ff <= seg_in;
      end
      if (ctl.load3) begin
         q_ff <= q_in;
      end
   end

   assign q = q_ff;

endmodule

### rtl/vario_tone_mapper_top.sv
// ----------------------------------------------------------------------------
// Variometer tone mapper
// Maps one climb-rate sample to one tone command: climb beep, sink tone or idle.
// ----------------------------------------------------------------------------
// The block takes one climb-rate item per clock while req_stall is low and
// returns one tone command per item. It is a four-stage pipeline: threshold
// test and breakpoint search, interpolation numerator, reciprocal multiply,
// and the output register. Each stage holds only while its successor is full
// and stalled, so bubbles close up under rsp_stall and req_stall rises only
// once all four stages hold items. Climb tones come from two fixed breakpoint
// tables (frequency and beep length) interpolated with truncation; silence
// after a beep equals the beep. The user must write registers through the csr
// port only while no item is in flight; the block does not enforce this.
module vario_tone_mapper_top import vtm_pkg::*; #(
   parameter int NUM_POINTS = DEF_NUM_POINTS
) (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [X_W-1:0]     req_climb_rate,
   // response channel
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [MODE_W-1:0]         rsp_tone_mode,
   output logic [HZ_W-1:0]           rsp_tone_hz,
   output logic [MS_W-1:0]           rsp_tone_on_ms,
   output logic [MS_W-1:0]           rsp_silence_ms,
   // configuration
   input  logic                      csr_we,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_W-1:0]          csr_wdata
);

   localparam int N_USE = (NUM_POINTS < ROM_LEN) ? NUM_POINTS : ROM_LEN;

   // Configuration registers
   logic signed [X_W-1:0] climb_thr_ff, climb_thr_in;
   logic signed [X_W-1:0] sink_thr_ff, sink_thr_in;
   logic [HZ_W-1:0]       sink_hz_ff, sink_hz_in;
   logic [MS_W-1:0]       sink_period_ff, sink_period_in;
   logic [MS_W-1:0]       idle_period_ff, idle_period_in;

   // Pipeline handshake
   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in, v4_ff, v4_in;
   logic ready1, ready2, ready3, ready4;
   vtm_ctl_type ctl;

   // Stage 1
   tone_mode_type         mode1_ff, mode1_in;
   logic signed [X_W-1:0] x1_ff, x1_in;
   logic [IDX_W-1:0]      seg1_ff, seg1_in;
   logic                  lo1_ff, lo1_in, hi1_ff, hi1_in;

   // Stage 2 / 3
   tone_mode_type         mode2_ff, mode3_ff;
   logic [DXX_W-1:0]      dxx;
   logic signed [X_W-1:0] x_left, x_off;
   logic [IDX_W-1:0]      seg_left;
   logic [Q_W-1:0]        q_hz, q_ms;

   // Stage 4 (output register)
   tone_mode_type   mode4_ff, mode4_in;
   logic [HZ_W-1:0] hz4_ff, hz4_in;
   logic [MS_W-1:0] on4_ff, on4_in;
   logic [MS_W-1:0] sil4_ff, sil4_in;

   // Decode register writes
   always_comb begin
      climb_thr_in   = climb_thr_ff;
      sink_thr_in    = sink_thr_ff;
      sink_hz_in     = sink_hz_ff;
      sink_period_in = sink_period_ff;
      idle_period_in = idle_period_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_CLIMB_THR:   climb_thr_in   = $signed(csr_wdata[X_W-1:0]);
            CSR_SINK_THR:    sink_thr_in    = $signed(csr_wdata[X_W-1:0]);
            CSR_SINK_HZ:     sink_hz_in     = csr_wdata[HZ_W-1:0];
            CSR_SINK_PERIOD: sink_period_in = csr_wdata[MS_W-1:0];
            CSR_IDLE_PERIOD: idle_period_in = csr_wdata[MS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         climb_thr_ff   <= 12'sd20;
         sink_thr_ff    <= -12'sd200;
         sink_hz_ff     <= 11'd150;
         sink_period_ff <= 10'd500;
         idle_period_ff <= 10'd100;
      end else begin
         climb_thr_ff   <= climb_thr_in;
         sink_thr_ff    <= sink_thr_in;
         sink_hz_ff     <= sink_hz_in;
         sink_period_ff <= sink_period_in;
         idle_period_ff <= idle_period_in;
      end
   end

   // Each stage advances when it is empty or its successor advances
   always_comb begin
      ready4    = !v4_ff || !rsp_stall;
      ready3    = !v3_ff || ready4;
      ready2    = !v2_ff || ready3;
      ready1    = !v1_ff || ready2;
      req_stall = !ready1;
      ctl.load2 = ready2;
      ctl.load3 = ready3;
      v1_in     = ready1 ? req_valid : v1_ff;
      v2_in     = ready2 ? v1_ff : v2_ff;
      v3_in     = ready3 ? v2_ff : v3_ff;
      v4_in     = ready4 ? v3_ff : v4_ff;
   end

   // Stage 1: classify, clamp and find the breakpoint segment
   always_comb begin
      if (req_climb_rate >= climb_thr_ff) begin
         mode1_in = MODE_CLIMB;
      end else if (req_climb_rate <= sink_thr_ff) begin
         mode1_in = MODE_SINK;
      end else begin
         mode1_in = MODE_SILENT;
      end
      x1_in  = (req_climb_rate > CLIMB_CLAMP) ? CLIMB_CLAMP : req_climb_rate;
      lo1_in = x1_in <= $signed(X_W'(BP_X[0]));
      hi1_in = x1_in > $signed(X_W'(BP_X[N_USE-1]));
      seg1_in = IDX_W'(N_USE - 1);
      // first breakpoint at or above the rate wins
      for (int i = N_USE - 1; i >= 1; i--) begin
         if (x1_in <= $signed(X_W'(BP_X[i]))) begin
            seg1_in = IDX_W'(i);
         end
      end
   end

   // Stage 2 input: offset into the segment (zero below, full length above)
   always_comb begin
      seg_left = seg1_ff - 1'b1;
      x_left   = $signed(X_W'(BP_X[seg_left]));
      x_off    = x1_ff - x_left;
      if (lo1_ff) begin
         dxx = '0;
      end else if (hi1_ff) begin
         dxx = DXX_W'(SEG_DX[seg1_ff]);
      end else begin
         dxx = x_off[DXX_W-1:0];
      end
   end

   vtm_interp #(.Y_TABLE(BP_HZ)) u_interp_hz (
      .clock (clock),
      .ctl   (ctl),
      .seg   (seg1_ff),
      .dxx   (dxx),
      .q     (q_hz)
   );

   vtm_interp #(.Y_TABLE(BP_MS)) u_interp_ms (
      .clock (clock),
      .ctl   (ctl),
      .seg   (seg1_ff),
      .dxx   (dxx),
      .q     (q_ms)
   );

   // Stage 4: assemble the tone command
   always_comb begin
      mode4_in = mode3_ff;
      case (mode3_ff)
         MODE_CLIMB: begin
            hz4_in  = q_hz[HZ_W-1:0];
            on4_in  = q_ms[MS_W-1:0];
            sil4_in = q_ms[MS_W-1:0];
         end
         MODE_SINK: begin
            hz4_in  = sink_hz_ff;
            on4_in  = sink_period_ff;
            sil4_in = '0;
         end
         default: begin
            hz4_in  = '0;
            on4_in  = '0;
            sil4_in = idle_period_ff;
         end
      endcase
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (ready1) begin
         mode1_ff <= mode1_in;
         x1_ff    <= x1_in;
         seg1_ff  <= seg1_in;
         lo1_ff   <= lo1_in;
         hi1_ff   <= hi1_in;
      end
      if (ready2) begin
         mode2_ff <= mode1_ff;
      end
      if (ready3) begin
         mode3_ff <= mode2_ff;
      end
      if (ready4) begin
         mode4_ff <= mode4_in;
         hz4_ff   <= hz4_in;
         on4_ff   <= on4_in;
         sil4_ff  <= sil4_in;
      end
   end

   assign rsp_valid      = v4_ff;
   assign rsp_tone_mode  = mode4_ff;
   assign rsp_tone_hz    = hz4_ff;
   assign rsp_tone_on_ms = on4_ff;
   assign rsp_silence_ms = sil4_ff;

   // Silent command carries no tone
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_tone_mode == MODE_SILENT) |->
         (rsp_tone_hz == '0 && rsp_tone_on_ms == '0))
      else $error("silent command with tone");

   // Climb beep: pause equals beep, values stay within the table span
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_tone_mode == MODE_CLIMB) |->
         (rsp_silence_ms == rsp_tone_on_ms
          && rsp_tone_hz >= 11'd300 && rsp_tone_hz <= 11'd1800
          && rsp_tone_on_ms >= 10'd30 && rsp_tone_on_ms <= 10'd200))
      else $error("climb command outside table span");

   // A stage never loads while it holds an item its successor refused
   assert property (@(posedge clock) disable iff (reset)
      (v4_ff && rsp_stall && v3_ff) |-> req_stall == !ready1 && !ready3)
      else $error("pipeline advanced into a full stage");

endmodule

### sim/vario_tone_mapper_top_test.sv
// ----------------------------------------------------------------------------
// Variometer tone mapper testbench
// Drives climb-rate items through the tone mapper under several register
// settings and random idling on both channels. A scoreboard predicts each
// tone command from its own copy of the breakpoint tables and registers and
// checks every returned command, field by field and in order.
// ----------------------------------------------------------------------------
module vario_tone_mapper_top_test;
   import vtm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PIPE_DEPTH   = 4;
   localparam int QUIET_LIMIT  = 2000;
   localparam int SHOW_LIMIT   = 10;
   localparam int TAB_LEN      = 20;
   localparam int RATE_CEILING = 1000;

   // Breakpoints of the climb tone: rate in cm/s, frequency, beep length
   localparam int BREAK_X  [TAB_LEN] = '{
      0, 20, 40, 60, 80, 100, 125, 150, 175, 200,
      225, 250, 350, 424, 500, 600, 700, 800, 900, 1000
   };
   localparam int BREAK_HZ [TAB_LEN] = '{
      300, 350, 400, 450, 500, 550, 600, 650, 700, 750,
      800, 850, 950, 1050, 1150, 1300, 1450, 1600, 1700, 1800
   };
   localparam int BREAK_MS [TAB_LEN] = '{
      200, 190, 180, 170, 160, 150, 140, 130, 120, 110,
      100, 90, 80, 70, 60, 50, 45, 40, 35, 30
   };

   typedef struct {
      tone_mode_type    mode;
      logic [HZ_W-1:0]  hz;
      logic [MS_W-1:0]  on_ms;
      logic [MS_W-1:0]  sil_ms;
   } tone_cmd_type;

   // Scoreboard: register copy, tone predictor and queue of expected commands
   class tone_board_type;
      int               climb_thr;
      int               sink_thr;
      logic [HZ_W-1:0]  sink_hz;
      logic [MS_W-1:0]  sink_ms;
      logic [MS_W-1:0]  idle_ms;
      tone_cmd_type     expected_cmds[$];
      int               n_errors;
      int               n_checked;

      function new();
         climb_thr = 20;
         sink_thr  = -200;
         sink_hz   = 150;
         sink_ms   = 500;
         idle_ms   = 100;
         n_errors  = 0;
         n_checked = 0;
      endfunction

      // Mirror a register write; indexes past the list are ignored
      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] d);
         case (idx)
            CSR_CLIMB_THR:   climb_thr = int'($signed(d[X_W-1:0]));
            CSR_SINK_THR:    sink_thr  = int'($signed(d[X_W-1:0]));
            CSR_SINK_HZ:     sink_hz   = d[HZ_W-1:0];
            CSR_SINK_PERIOD: sink_ms   = d[MS_W-1:0];
            CSR_IDLE_PERIOD: idle_ms   = d[MS_W-1:0];
            default: ;
         endcase
      endfunction

      // Piecewise-linear lookup with truncation, beep length or frequency
      function int interp(bit want_ms, int x);
         int dx;
         int num;
         int y0;
         int y1;
         if (x <= BREAK_X[0]) return want_ms ? BREAK_MS[0] : BREAK_HZ[0];
         for (int i = 1; i < TAB_LEN; i++) begin
            if (x <= BREAK_X[i]) begin
               y0  = want_ms ? BREAK_MS[i-1] : BREAK_HZ[i-1];
               y1  = want_ms ? BREAK_MS[i]   : BREAK_HZ[i];
               dx  = BREAK_X[i] - BREAK_X[i-1];
               num = y0 * dx + (x - BREAK_X[i-1]) * (y1 - y0);
               if (num < 0) num = 0;
               return num / dx;
            end
         end
         return want_ms ? BREAK_MS[TAB_LEN-1] : BREAK_HZ[TAB_LEN-1];
      endfunction

      function tone_cmd_type predict_cmd(logic signed [X_W-1:0] rate);
         tone_cmd_type c;
         int        r;
         int        x;
         int        beep;
         r = int'(rate);
         if (r >= climb_thr) begin
            x        = (r > RATE_CEILING) ? RATE_CEILING : r;
            beep     = interp(1'b1, x);
            c.mode   = MODE_CLIMB;
            c.hz     = HZ_W'(interp(1'b0, x));
            c.on_ms  = MS_W'(beep);
            c.sil_ms = MS_W'(beep);
         end else if (r <= sink_thr) begin
            c.mode   = MODE_SINK;
            c.hz     = sink_hz;
            c.on_ms  = sink_ms;
            c.sil_ms = '0;
         end else begin
            c.mode   = MODE_SILENT;
            c.hz     = '0;
            c.on_ms  = '0;
            c.sil_ms = idle_ms;
         end
         return c;
      endfunction

      // Append the predicted command at the tail of the queue
      function void note_rate(logic signed [X_W-1:0] rate);
         expected_cmds = {expected_cmds, predict_cmd(rate)};
      endfunction

      function int pending();
         return expected_cmds.size();
      endfunction

      function void check_cmd(logic [MODE_W-1:0] mode, logic [HZ_W-1:0] hz,
                              logic [MS_W-1:0] on_ms, logic [MS_W-1:0] sil_ms);
         tone_cmd_type e;
         n_checked++;
         if (expected_cmds.size() == 0) begin
            n_errors++;
            if (n_errors <= SHOW_LIMIT)
               $display("%0t: unexpected command mode=%0d hz=%0d on=%0d sil=%0d",
                        $realtime, mode, hz, on_ms, sil_ms);
            return;
         end
         e = expected_cmds.pop_front();
         if (mode !== e.mode || hz !== e.hz || on_ms !== e.on_ms || sil_ms !== e.sil_ms)
         begin
            n_errors++;
            if (n_errors <= SHOW_LIMIT)
               $display("%0t: mismatch exp mode=%0d hz=%0d on=%0d sil=%0d, got %0d %0d %0d %0d",
                        $realtime, e.mode, e.hz, e.on_ms, e.sil_ms,
                        mode, hz, on_ms, sil_ms);
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic signed [X_W-1:0] req_climb_rate = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [MODE_W-1:0]     rsp_tone_mode;
   logic [HZ_W-1:0]       rsp_tone_hz;
   logic [MS_W-1:0]       rsp_tone_on_ms;
   logic [MS_W-1:0]       rsp_silence_ms;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_W-1:0]      csr_wdata = '0;

   tone_board_type        sb = new();
   int                    send_idle_pct = 0;
   int                    recv_idle_pct = 0;
   int                    rates_sent = 0;
   int                    settings_used = 0;
   int                    quiet_cycles = 0;

   vario_tone_mapper_top DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_climb_rate (req_climb_rate),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_tone_mode  (rsp_tone_mode),
      .rsp_tone_hz    (rsp_tone_hz),
      .rsp_tone_on_ms (rsp_tone_on_ms),
      .rsp_silence_ms (rsp_silence_ms),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stall the result channel at random
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Check every accepted tone command
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_cmd(rsp_tone_mode, rsp_tone_hz, rsp_tone_on_ms, rsp_silence_ms);
   end

   // Watchdog: end the run after too long without any item moving
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("vario_tone_mapper_top_test: errors");
            $finish;
         end
      end
   end

   // Offer one rate item, idling first at random, and hold it until taken
   task automatic push_rate(input logic signed [X_W-1:0] rate);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_climb_rate <= rate;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_rate(rate);
      rates_sent++;
   endtask

   // Drop valid and wait until the pipeline has drained
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 2) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] d);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(negedge clock);
      csr_we    <= 1'b0;
      sb.write_reg(idx, d);
   endtask

   task automatic write_all(input int climb, input int sink, input int hz,
                            input int sink_per, input int idle_per);
      write_csr(CSR_CLIMB_THR,   CSR_W'(climb));
      write_csr(CSR_SINK_THR,    CSR_W'(sink));
      write_csr(CSR_SINK_HZ,     CSR_W'(hz));
      write_csr(CSR_SINK_PERIOD, CSR_W'(sink_per));
      write_csr(CSR_IDLE_PERIOD, CSR_W'(idle_per));
      settings_used++;
   endtask

   // Random setting; upper data bits of narrow registers are random too
   task automatic random_setup();
      int sink;
      sink = ($urandom_range(4) == 0) ? int'($urandom_range(300)) - 100
                                      : -int'($urandom_range(900));
      write_all(int'($urandom_range(400)) - 150, sink, int'($urandom_range(4095)),
                int'($urandom_range(4095)), int'($urandom_range(4095)));
      // writes past the register list must leave everything alone
      repeat ($urandom_range(1, 2))
         write_csr(CSR_IDLE_PERIOD + CSR_IDX_W'($urandom_range(1, 3)),
                   CSR_W'($urandom_range(4095)));
   endtask

   // Rate biased toward the breakpoints and the thresholds
   function automatic logic signed [X_W-1:0] pick_rate();
      int sel;
      sel = $urandom_range(99);
      if (sel < 40)      return X_W'($urandom_range(1100));
      else if (sel < 55) return X_W'(sb.climb_thr + int'($urandom_range(6)) - 3);
      else if (sel < 65) return X_W'(sb.sink_thr + int'($urandom_range(6)) - 3);
      else if (sel < 75) return X_W'(BREAK_X[$urandom_range(TAB_LEN - 1)]
                                     + int'($urandom_range(2)) - 1);
      else               return X_W'($urandom());
   endfunction

   task automatic run_random(input int n);
      repeat (n) push_rate(pick_rate());
   endtask

   initial begin
      int rates_a[] = '{-2048, 2047, -2000, 2000, 0, 19, 20, 21, -199, -200, -201,
                        999, 1000, 1001, 423, 424, 425, 350, 112, 130, 612};
      int rates_b[] = '{-2048, -1, 0, 5};

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Sender idles lightly, receiver heavily
      send_idle_pct = 20;
      recv_idle_pct = 64;

      // Reset setting: field extremes, thresholds, clamp and breakpoints
      foreach (rates_a[i]) push_rate(X_W'(rates_a[i]));
      settle();

      // Lowest climb threshold, overlapping sink threshold, widest fields
      write_all(-2048, 2047, 2047, 1023, 1023);
      foreach (rates_b[i]) push_rate(X_W'(rates_b[i]));
      run_random(100);
      settle();

      // Highest climb threshold, lowest sink threshold, zero fields
      write_all(2047, -2048, 0, 0, 0);
      run_random(100);
      settle();

      // Sender idles heavily, receiver lightly
      send_idle_pct = 64;
      recv_idle_pct = 20;
      for (int p = 0; p < 2; p++) begin
         random_setup();
         run_random(105);
         settle();
      end

      // No idling on either side
      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int p = 0; p < 2; p++) begin
         random_setup();
         run_random(105);
         settle();
      end

      sb.n_errors += sb.pending();
      $display("covered %0d rate items and %0d tone commands over %0d register settings",
               rates_sent, sb.n_checked, settings_used);
      $display("three idling modes on both channels, %0d mismatches", sb.n_errors);
      if (sb.n_errors == 0)
         $display("vario_tone_mapper_top_test: clean");
      else
         $display("vario_tone_mapper_top_test: errors");
      $finish;
   end

endmodule
